// ----- src/temp_scratchpad_check_decode_assert.svh -----
// Assertion macros for the scratchpad check and decode block.
// Used by the top level; expects clk and rst_n in scope.
`ifndef TEMP_SCRATCHPAD_CHECK_DECODE_ASSERT_SVH
`define TEMP_SCRATCHPAD_CHECK_DECODE_ASSERT_SVH

// Same-cycle implication, off during reset.
`define TSCD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");

// Next-cycle implication, off during reset.
`define TSCD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

// ----- src/tscd_pkg.sv -----
// Shared types, constants and the CRC8 step for the scratchpad decoder.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package tscd_pkg;

  // Frame layout.
  localparam int FRAME_BYTES = 9;
  localparam int IDX_W       = 4;
  localparam logic [IDX_W-1:0] IDX_RAW_LO = 4'd0;
  localparam logic [IDX_W-1:0] IDX_RAW_HI = 4'd1;
  localparam logic [IDX_W-1:0] IDX_TH     = 4'd2;
  localparam logic [IDX_W-1:0] IDX_TL     = 4'd3;
  localparam logic [IDX_W-1:0] IDX_CONF   = 4'd4;
  localparam logic [IDX_W-1:0] IDX_CALC   = 4'd5;
  localparam logic [IDX_W-1:0] IDX_CRC    = IDX_W'(FRAME_BYTES - 1);

  // Value widths and markers.
  localparam int TEMP_W = 19;
  localparam logic signed [TEMP_W-1:0] INVALID_MARK = -19'sd27400;
  localparam logic [7:0] CRC_POLY = 8'h8C;
  localparam logic [1:0] ERR_MAX  = 2'd3;

  typedef enum logic [1:0] {
    STATUS_OK          = 2'd0,
    STATUS_NOT_READY   = 2'd1,
    STATUS_CRC_BAD     = 2'd2,
    STATUS_IMPLAUSIBLE = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CFG_UPPER_LIMIT = 2'd0,
    CFG_LOWER_LIMIT = 2'd1,
    CFG_MAX_STEP    = 2'd2
  } cfg_idx_t;

  // One finished frame as handed from the front to the back.
  typedef struct packed {
    logic signed [TEMP_W-1:0] value;
    logic                     not_ready;
    logic                     crc_ok;
  } frame_rec_t;

  // Queue status seen by both sides.
  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  // One byte of the reflected Dallas/Maxim CRC8, LSB first.
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in,
                                           input logic [7:0] data);
    logic [7:0] crc;
    logic [7:0] d;
    logic       mix;
    crc = crc_in;
    d   = data;
    for (int i = 0; i < 8; i++) begin
      mix = crc[0] ^ d[0];
      crc = crc >> 1;
      if (mix) begin
        crc = crc ^ CRC_POLY;
      end
      d = d >> 1;
    end
    return crc;
  endfunction

endpackage

`default_nettype wire

// ----- src/tscd_fifo.sv -----
// Two-entry queue of frame records between the front and the back.
// Depends on tscd_pkg for the record and status types.
`timescale 1ns / 1ps
`default_nettype none

module tscd_fifo
  import tscd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       push,
  input  wire frame_rec_t push_rec,
  input  wire logic       pop,
  output frame_rec_t      head_rec,
  output fifo_stat_t      stat
);

  frame_rec_t  mem_r [2];
  logic        wr_ptr_r, wr_ptr_nxt;
  logic        rd_ptr_r, rd_ptr_nxt;
  logic [1:0]  count_r, count_nxt;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop  ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_rec;
    end
  end

  assign head_rec   = mem_r[rd_ptr_r];
  assign stat.full  = count_r[1];
  assign stat.empty = (count_r == 2'd0);

endmodule

`default_nettype wire

// ----- src/tscd_front.sv -----
// Front part: takes scratchpad bytes, runs the CRC, collects the raw
// fields and pushes one frame record per frame. Depends on tscd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tscd_front
  import tscd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       accept,
  input  wire logic [7:0] data_byte,
  input  wire logic       frame_start,
  output logic            push,
  output frame_rec_t      push_rec
);

  logic [IDX_W-1:0]         idx_r, idx_nxt;
  logic [7:0]               crc_r, crc_nxt;
  logic                     nr_r, nr_nxt;
  logic [7:0]               lo_r, hi_r;
  logic [1:0]               res_r;
  logic signed [TEMP_W-1:0] value_r;

  logic [IDX_W-1:0]         eff_idx;
  logic [7:0]               crc_base;
  logic                     nr_base;
  logic [15:0]              u_masked;
  logic signed [20:0]       prod;
  logic signed [20:0]       prod_adj;

  // A frame start forces byte 0; byte 0 restarts the CRC and the not-ready flag.
  always_comb begin
    eff_idx  = frame_start ? IDX_RAW_LO : idx_r;
    crc_base = (eff_idx == IDX_RAW_LO) ? 8'h00 : crc_r;
    nr_base  = (eff_idx == IDX_RAW_LO) ? 1'b0 : nr_r;
  end

  // Byte counter, CRC and not-ready tracking.
  always_comb begin
    idx_nxt = idx_r;
    crc_nxt = crc_r;
    nr_nxt  = nr_r;
    push    = 1'b0;
    if (accept) begin
      if (eff_idx == IDX_CRC) begin
        idx_nxt = IDX_RAW_LO;
        push    = 1'b1;
      end else begin
        idx_nxt = eff_idx + 4'd1;
        crc_nxt = crc8_byte(crc_base, data_byte);
        nr_nxt  = nr_base |
                  (((eff_idx == IDX_TH) || (eff_idx == IDX_TL)) && (data_byte != 8'h00));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= IDX_RAW_LO;
      crc_r <= 8'h00;
      nr_r  <= 1'b0;
    end else begin
      idx_r <= idx_nxt;
      crc_r <= crc_nxt;
      nr_r  <= nr_nxt;
    end
  end

  // Resolution mask on the raw reading.
  always_comb begin
    case (res_r)
      2'd0:    u_masked = {hi_r, lo_r} & 16'hFFF8;
      2'd1:    u_masked = {hi_r, lo_r} & 16'hFFFC;
      2'd2:    u_masked = {hi_r, lo_r} & 16'hFFFE;
      default: u_masked = {hi_r, lo_r};
    endcase
  end

  // raw*100/16 is raw*25/4; round toward zero by biasing negatives before the shift.
  always_comb begin
    prod     = $signed({{5{u_masked[15]}}, u_masked}) * 21'sd25;
    prod_adj = prod + (prod[20] ? 21'sd3 : 21'sd0);
  end

  // Raw fields are taken at their byte; the decode runs on byte 5 once they are all in.
  always_ff @(posedge clk) begin
    if (accept) begin
      if (eff_idx == IDX_RAW_LO) begin
        lo_r <= data_byte;
      end
      if (eff_idx == IDX_RAW_HI) begin
        hi_r <= data_byte;
      end
      if (eff_idx == IDX_CONF) begin
        res_r <= data_byte[6:5];
      end
      if (eff_idx == IDX_CALC) begin
        value_r <= TEMP_W'(prod_adj >>> 2);
      end
    end
  end

  assign push_rec.value     = value_r;
  assign push_rec.not_ready = nr_r;
  assign push_rec.crc_ok    = (crc_r == data_byte);

endmodule

`default_nettype wire

// ----- src/tscd_back.sv -----
// Back part: judges each frame record against the limits and history,
// keeps the error counter and the output register. Depends on tscd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tscd_back
  import tscd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [TEMP_W-1:0] cfg_data,
  input  wire logic              rec_valid,
  input  wire frame_rec_t        rec,
  output logic                   pop,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [1:0]             out_status,
  output logic [TEMP_W-1:0]      out_temp,
  output logic [1:0]             out_level
);

  logic signed [TEMP_W-1:0] upper_r, lower_r;
  logic [TEMP_W-1:0]        step_r;
  logic signed [TEMP_W-1:0] prev_r, prev_nxt;
  logic [1:0]               cnt_r, cnt_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [1:0]               out_status_r;
  logic [TEMP_W-1:0]        out_temp_r;
  logic [1:0]               out_level_r;

  logic signed [20:0]       diff;
  logic signed [20:0]       step_s;
  logic                     up_bad, lo_bad, step_bad;
  status_t                  status;

  // Limit registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upper_r <= '0;
      lower_r <= '0;
      step_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_UPPER_LIMIT: upper_r <= $signed(cfg_data);
        CFG_LOWER_LIMIT: lower_r <= $signed(cfg_data);
        CFG_MAX_STEP:    step_r  <= cfg_data;
        default:         ;
      endcase
    end
  end

  // A record moves on when the output register is empty or being emptied.
  assign pop = rec_valid && (!out_valid_r || out_ready);

  // Plausibility checks.
  always_comb begin
    diff     = 21'(rec.value) - 21'(prev_r);
    step_s   = $signed({2'b00, step_r});
    up_bad   = (upper_r != '0) && (rec.value > upper_r);
    lo_bad   = (lower_r != '0) && (rec.value < lower_r);
    step_bad = (step_r != '0) && (prev_r > INVALID_MARK) &&
               ((diff > step_s) || (-diff > step_s));
  end

  // Status precedence: not ready, then CRC, then implausible.
  always_comb begin
    if (rec.not_ready) begin
      status = STATUS_NOT_READY;
    end else if (!rec.crc_ok) begin
      status = STATUS_CRC_BAD;
    end else if (up_bad || lo_bad || step_bad) begin
      status = STATUS_IMPLAUSIBLE;
    end else begin
      status = STATUS_OK;
    end
  end

  // Saturating error counter and kept value.
  always_comb begin
    cnt_nxt  = cnt_r;
    prev_nxt = prev_r;
    if (pop) begin
      if (status != STATUS_OK) begin
        cnt_nxt = (cnt_r == ERR_MAX) ? ERR_MAX : cnt_r + 2'd1;
      end else begin
        cnt_nxt = (cnt_r == 2'd0) ? 2'd0 : cnt_r - 2'd1;
      end
      prev_nxt = (cnt_nxt != 2'd0) ? INVALID_MARK : rec.value;
    end
  end

  always_comb begin
    if (pop) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= 2'd0;
      prev_r      <= INVALID_MARK;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      prev_r      <= prev_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Output payload register.
  always_ff @(posedge clk) begin
    if (pop) begin
      out_status_r <= status;
      out_temp_r   <= prev_nxt;
      out_level_r  <= cnt_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_temp   = out_temp_r;
  assign out_level  = out_level_r;

endmodule

`default_nettype wire

// ----- src/temp_scratchpad_check_decode.sv -----
// Top level of the scratchpad check and decode block.
// Depends on tscd_pkg, tscd_front, tscd_fifo, tscd_back and the assert header.
`timescale 1ns / 1ps
`default_nettype none
`include "temp_scratchpad_check_decode_assert.svh"

// Takes one scratchpad byte per clock while the queue is not full, byte 0
// first (tuser marks byte 0), checks the CRC8 over bytes 0 to 7 against
// byte 8 and, for each ninth byte, delivers one word with the status, the
// temperature in hundredths of a degree and the error level. When the
// output register is free, out_tvalid rises at the clock edge after the one
// that takes the CRC byte. Two finished frames can wait in the queue
// between the byte front and the judging back, so bytes keep flowing while
// a result is held by the sink; tready drops only when both queue slots are
// taken. Limit writes are accepted in every cycle and should be done while
// no frame is in flight.
module temp_scratchpad_check_decode
  import tscd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Byte stream in.
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] data_byte
  input  wire logic        in_tuser,   // [0] frame_start
  // Result stream out.
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,  // [1:0] status, [20:2] temperature_centi,
                                       // [22:21] error_level, [23] zero
  // Limit writes.
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [18:0] cfg_data
);

  logic              in_accept;
  logic              push;
  logic              pop;
  frame_rec_t        push_rec;
  frame_rec_t        head_rec;
  fifo_stat_t        q_stat;
  logic [1:0]        out_status;
  logic [TEMP_W-1:0] out_temp;
  logic [1:0]        out_level;

  assign in_tready = !q_stat.full;
  assign in_accept = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  tscd_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (in_accept),
    .data_byte   (in_tdata),
    .frame_start (in_tuser),
    .push        (push),
    .push_rec    (push_rec)
  );

  tscd_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_rec (push_rec),
    .pop      (pop),
    .head_rec (head_rec),
    .stat     (q_stat)
  );

  tscd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .rec_valid  (!q_stat.empty),
    .rec        (head_rec),
    .pop        (pop),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_status (out_status),
    .out_temp   (out_temp),
    .out_level  (out_level)
  );

  // Pack the result word.
  assign out_tdata = {1'b0, out_level, out_temp, out_status};

  // Any pending error level forces the marker value.
  `TSCD_ASSERT_NOW(a_marker_on_error, out_tvalid && (out_level != 2'd0),
                   $signed(out_temp) == INVALID_MARK)
  // A failed frame always leaves a nonzero error level.
  `TSCD_ASSERT_NOW(a_level_on_fail, out_tvalid && (out_status != STATUS_OK),
                   out_level != 2'd0)
  // The queue is never full and empty at once.
  `TSCD_ASSERT_NOW(a_queue_sane, 1'b1, !(q_stat.full && q_stat.empty))
  // A frame record is never taken from an empty queue.
  `TSCD_ASSERT_NOW(a_no_pop_empty, pop, !q_stat.empty)

endmodule

`default_nettype wire

// ----- tb/sv/tb_top.sv -----
// Self-checking bench for the scratchpad check and decode block.
// Depends on tscd_pkg and temp_scratchpad_check_decode; streams scratchpad
// frames with random pacing and checks every result word against a model.
`timescale 1ns / 1ps

module tb_top;
  import tscd_pkg::*;

  localparam int  WATCHDOG_LIMIT = 2000;
  localparam int  RESULT_WAIT    = 500;
  localparam int  SETTLE_CYCLES  = 8;
  localparam int  PHASES         = 12;
  localparam int  CENTI_MAX      = 204793;
  localparam int  CENTI_MIN      = -204800;
  localparam int  STEP_MAX       = 409600;
  localparam logic [1:0] CFG_SPARE_IDX = 2'd3;  // not a register, must be ignored

  typedef enum {FRAME_GOOD, FRAME_NOT_READY, FRAME_BAD_CRC} frame_kind_t;

  typedef struct packed {
    logic       start;
    logic [7:0] data;
  } scratch_byte_t;

  typedef struct packed {
    status_t           status;
    logic [TEMP_W-1:0] centi;
    logic [1:0]        level;
  } decode_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;   // [7:0] data_byte
  logic        in_tuser = 1'b0; // [0] frame_start
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;       // [1:0] status, [20:2] temperature_centi,
                                // [22:21] error_level, [23] zero
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [18:0] cfg_data = '0;

  // Stimulus bookkeeping.
  scratch_byte_t scratch_q[$];
  decode_word_t  pending_decodes[$];
  int bytes_queued = 0;
  int bytes_taken = 0;
  int gen_pos = 0;
  int base_raw = 400;
  bit pace_on = 1'b1;
  int send_gap = 0;
  int sink_stall = 0;
  int words_seen = 0;
  int fail_count = 0;
  int quiet_cycles = 0;

  // Model copy of the limit registers.
  int lim_hi = 0;
  int lim_lo = 0;
  int lim_step = 0;

  // Model copy of the frame state.
  logic [3:0] frame_pos = '0;
  logic [7:0] crc_run = '0;
  logic [7:0] lo_byte = '0;
  logic [7:0] hi_byte = '0;
  logic [1:0] res_sel = '0;
  logic       conv_busy = 1'b0;
  int         last_centi = int'(INVALID_MARK);
  logic [1:0] err_level = '0;

  temp_scratchpad_check_decode DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 0;
  end

  // Reflected CRC8: fold the whole byte in, then shift out eight bits.
  function automatic logic [7:0] crc8_step(input logic [7:0] acc, input logic [7:0] b);
    logic [7:0] c;
    c = acc ^ b;
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  // Advance the model by one accepted byte; byte 8 queues the expected word.
  function automatic void decode_scratch_byte(input logic [7:0] b, input logic start);
    status_t      st;
    logic [15:0]  u;
    int           raw;
    int           centi;
    int           diff;
    logic         bad;
    decode_word_t w;
    if (start) begin
      frame_pos = '0;
    end
    if (frame_pos == IDX_RAW_LO) begin
      crc_run   = '0;
      conv_busy = 1'b0;
    end
    if (frame_pos != IDX_CRC) begin
      case (frame_pos)
        IDX_RAW_LO: lo_byte = b;
        IDX_RAW_HI: hi_byte = b;
        IDX_TH, IDX_TL: if (b != 8'h00) conv_busy = 1'b1;
        IDX_CONF: res_sel = b[6:5];
        default: ;
      endcase
      crc_run   = crc8_step(crc_run, b);
      frame_pos = frame_pos + 1'b1;
      return;
    end

    // CRC byte: judge the frame.
    frame_pos = '0;
    centi     = 0;
    if (conv_busy) begin
      st = STATUS_NOT_READY;
    end else if (crc_run != b) begin
      st = STATUS_CRC_BAD;
    end else begin
      u = {hi_byte, lo_byte};
      case (res_sel)
        2'd0: u[2:0] = '0;
        2'd1: u[1:0] = '0;
        2'd2: u[0] = 1'b0;
        default: ;
      endcase
      raw   = int'($signed(u));
      centi = (raw * 100) / 16;
      bad   = 1'b0;
      if (lim_hi != 0 && centi > lim_hi) bad = 1'b1;
      if (lim_lo != 0 && centi < lim_lo) bad = 1'b1;
      if (lim_step != 0 && last_centi > int'(INVALID_MARK)) begin
        diff = centi - last_centi;
        if (diff > lim_step || diff < -lim_step) bad = 1'b1;
      end
      st = bad ? STATUS_IMPLAUSIBLE : STATUS_OK;
    end

    if (st != STATUS_OK) begin
      if (err_level != ERR_MAX) err_level = err_level + 1'b1;
    end else if (err_level != 2'd0) begin
      err_level = err_level - 1'b1;
    end
    last_centi = (err_level != 2'd0) ? int'(INVALID_MARK) : centi;

    w.status = st;
    w.centi  = last_centi[TEMP_W-1:0];
    w.level  = err_level;
    pending_decodes.push_back(w);
  endfunction

  // Idle length: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    if (!pace_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Raw reading: usually a slow drift, sometimes a jump, noise or a rail value.
  function automatic logic [15:0] pick_raw();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      base_raw = base_raw + int'($urandom_range(0, 60)) - 30;
    end else if (r < 65) begin
      base_raw = int'($urandom_range(0, 2880)) - 880;
    end else if (r < 85) begin
      return 16'($urandom);
    end else begin
      case ($urandom_range(0, 3))
        0: return 16'h7FFF;
        1: return 16'h8000;
        2: return 16'h0000;
        default: return 16'hFFFF;
      endcase
    end
    return 16'(base_raw);
  endfunction

  task automatic note_failure(input string msg);
    if (fail_count < 40) $display("ERROR @%0t: %s", $realtime, msg);
    fail_count++;
  endtask

  task automatic push_byte(input logic [7:0] b, input logic start);
    scratch_q.push_back('{start: start, data: b});
    bytes_queued++;
    if (start) gen_pos = 0;
    gen_pos = (gen_pos == FRAME_BYTES - 1) ? 0 : gen_pos + 1;
  endtask

  // Build one nine-byte scratchpad with a correct or damaged check byte.
  task automatic send_frame(input logic [15:0] raw, input logic [1:0] res,
                            input frame_kind_t kind, input logic lead);
    logic [7:0] sp [FRAME_BYTES];
    logic [7:0] acc;
    sp[0] = raw[7:0];
    sp[1] = raw[15:8];
    sp[2] = 8'h00;
    sp[3] = 8'h00;
    sp[4] = {1'($urandom), res, 5'($urandom)};
    for (int i = 5; i < FRAME_BYTES - 1; i++) sp[i] = 8'($urandom);
    if (kind == FRAME_NOT_READY) begin
      case ($urandom_range(0, 2))
        0: sp[2] = 8'($urandom_range(1, 255));
        1: sp[3] = 8'($urandom_range(1, 255));
        default: begin
          sp[2] = 8'($urandom_range(1, 255));
          sp[3] = 8'($urandom_range(1, 255));
        end
      endcase
    end
    acc = '0;
    for (int i = 0; i < FRAME_BYTES - 1; i++) acc = crc8_step(acc, sp[i]);
    sp[FRAME_BYTES-1] = acc;
    // A not-ready frame sometimes also carries a bad check byte.
    if (kind == FRAME_BAD_CRC || (kind == FRAME_NOT_READY && $urandom_range(0, 1) == 1))
      sp[FRAME_BYTES-1] = acc ^ 8'($urandom_range(1, 255));
    push_byte(sp[0], lead);
    for (int i = 1; i < FRAME_BYTES; i++) push_byte(sp[i], 1'b0);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [18:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_UPPER_LIMIT) lim_hi = int'($signed(val));
    else if (idx == CFG_LOWER_LIMIT) lim_lo = int'($signed(val));
    else if (idx == CFG_MAX_STEP) lim_step = int'(val);
  endtask

  // Wait until every queued byte is taken and every result word is back, or the result wait runs out.
  task automatic wait_idle();
    int n;
    while (bytes_taken != bytes_queued) @(posedge clk);
    for (n = 0; n < RESULT_WAIT && pending_decodes.size() != 0; n++) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Byte driver: hold a word until taken, then pause or present the next one.
  always @(posedge clk) begin : byte_driver
    scratch_byte_t nxt;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        decode_scratch_byte(in_tdata, in_tuser);
        bytes_taken++;
      end
      if (!in_tvalid || in_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_tvalid <= 1'b0;
        end else if (scratch_q.size() != 0) begin
          nxt = scratch_q.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= nxt.data;
          in_tuser  <= nxt.start;
          send_gap  = pick_gap();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compare each taken word with the oldest expectation.
  always @(posedge clk) begin : result_monitor
    decode_word_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (pending_decodes.size() == 0) begin
          note_failure($sformatf("word %0d arrived with nothing expected (data %h)",
                                 words_seen, out_tdata));
        end else begin
          want = pending_decodes.pop_front();
          if (out_tdata[1:0] !== want.status)
            note_failure($sformatf("word %0d status: got %0d, expected %0d",
                                   words_seen, out_tdata[1:0], want.status));
          if (out_tdata[20:2] !== want.centi)
            note_failure($sformatf("word %0d temperature: got %0d, expected %0d",
                                   words_seen, $signed(out_tdata[20:2]),
                                   $signed(want.centi)));
          if (out_tdata[22:21] !== want.level)
            note_failure($sformatf("word %0d error level: got %0d, expected %0d",
                                   words_seen, out_tdata[22:21], want.level));
          if (out_tdata[23] !== 1'b0)
            note_failure($sformatf("word %0d pad bit is not zero", words_seen));
        end
        words_seen++;
      end
      if (sink_stall > 0) begin
        sink_stall--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        if ($urandom_range(0, 99) < 25) sink_stall = pick_gap();
      end
    end
  end

  // Watchdog: too long without any handshake ends the run.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("** temp_scratchpad_check_decode: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    int hi;
    int lo;
    int stp;
    int n_frames;
    int pick;
    frame_kind_t kind;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Defaults written explicitly, plus a write to an index with no register.
    write_reg(CFG_UPPER_LIMIT, '0);
    write_reg(CFG_LOWER_LIMIT, '0);
    write_reg(CFG_MAX_STEP, '0);
    write_reg(CFG_SPARE_IDX, 19'h7FFFF);

    // Directed: hottest reading, then coldest with conversion busy and no
    // start flag, then a cut-off frame restarted by a frame with a bad CRC.
    send_frame(16'h7FFF, 2'd3, FRAME_GOOD, 1'b1);
    send_frame(16'h8000, 2'd0, FRAME_NOT_READY, 1'b0);
    push_byte(8'hFF, 1'b1);
    push_byte(8'h00, 1'b0);
    send_frame(16'hFFFF, 2'd3, FRAME_BAD_CRC, 1'b1);
    wait_idle();

    for (int phase = 1; phase <= PHASES; phase++) begin
      pace_on  = (phase % 3) != 1;
      n_frames = 16;
      case (phase % 5)
        0: begin
          hi = 0; lo = 0; stp = 0;
        end
        1: begin
          hi = CENTI_MAX; lo = CENTI_MIN; stp = STEP_MAX;
        end
        2: begin
          // Limits crossed: every decoded value is rejected.
          hi = CENTI_MIN; lo = CENTI_MAX; stp = 1;
          n_frames = 6;
        end
        3: begin
          hi  = $urandom_range(3000, 12500);
          lo  = -int'($urandom_range(500, 5500));
          stp = $urandom_range(30, 2000);
        end
        default: begin
          hi  = int'($urandom_range(0, CENTI_MAX - CENTI_MIN)) + CENTI_MIN;
          lo  = hi - int'($urandom_range(0, 80000));
          if (lo < CENTI_MIN) lo = CENTI_MIN;
          stp = $urandom_range(0, STEP_MAX);
        end
      endcase
      write_reg(CFG_UPPER_LIMIT, 19'(hi));
      write_reg(CFG_LOWER_LIMIT, 19'(lo));
      write_reg(CFG_MAX_STEP, 19'(stp));
      if ($urandom_range(0, 2) == 0) write_reg(CFG_SPARE_IDX, 19'($urandom));

      repeat (n_frames) begin
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
          // Loose bytes that break up the framing.
          repeat ($urandom_range(1, 8)) push_byte(8'($urandom), $urandom_range(0, 3) == 0);
        end
        pick = $urandom_range(0, 99);
        kind = (pick < 70) ? FRAME_GOOD : (pick < 85) ? FRAME_NOT_READY : FRAME_BAD_CRC;
        send_frame(pick_raw(), 2'($urandom), kind,
                   (gen_pos != 0) || ($urandom_range(0, 99) < 85));
      end
      // Close the phase on a frame boundary so the block is idle for writes.
      send_frame(pick_raw(), 2'($urandom), FRAME_GOOD, 1'b1);
      wait_idle();
    end

    if (pending_decodes.size() != 0)
      note_failure($sformatf("%0d expected words never arrived", pending_decodes.size()));
    if (fail_count == 0) begin
      $display("** temp_scratchpad_check_decode: PASSED **");
    end else begin
      $display("** temp_scratchpad_check_decode: FAILED **");
    end
    $finish;
  end

endmodule
